/* rtl/core/hpid_pkg.sv */
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared widths, constants, register map and stage structs for the turn PID.
// ----------------------------------------------------------------------------
package hpid_pkg;

    // Field widths
    localparam int HEAD_W    = 13;  // heading, 1/16 degree
    localparam int DIFF_W    = 14;  // raw goal - measured
    localparam int ERR_W     = 13;  // wrapped error, signed
    localparam int AERR_W    = 12;  // |error|, at most a half turn
    localparam int INTEG_W   = 15;  // stored integral, signed
    localparam int ACC_W     = 16;  // integral plus error before clamping
    localparam int DERIV_W   = 14;  // error difference, signed
    localparam int TICK_W    = 16;
    localparam int GAIN_W    = 20;
    localparam int DB_W      = 12;
    localparam int PCT_W     = 7;   // speed magnitude in percent
    localparam int SPEED_W   = 8;
    localparam int SUM_W     = 36;  // each product and the P+I+D sum
    localparam int MAG_W     = SUM_W - 1;
    localparam int DEG_SHIFT = 4;   // 1/16 degree to degree

    // Angle constants in 1/16 degree
    localparam int HALF_TURN        = 2880;
    localparam int FULL_TURN        = 5760;
    localparam int INTEG_RESET_BAND = 800;
    localparam int INTEG_LIMIT      = 16000;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd6;

    // Input function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_DONE    = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DB_W-1:0]   deadband;
        logic [PCT_W-1:0]  min_speed;
        logic [PCT_W-1:0]  max_speed;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    // Tracking stage -> multiply stage
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
        logic                      brake;
        logic                      done;
        status_t                   status;
    } track_t;

    // Multiply stage -> drive stage
    typedef struct packed {
        logic signed [SUM_W-1:0] p;
        logic signed [SUM_W-1:0] i;
        logic signed [SUM_W-1:0] d;
        logic                    brake;
        logic                    done;
        status_t                 status;
    } prod_t;

endpackage

/* rtl/core/hpid_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hpid_cfg_regs
// Configuration register file: gains, deadband, speed limits and timeout.
// ----------------------------------------------------------------------------
module hpid_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpid_pkg::CFG_W-1:0]     cfg_data,
    output hpid_pkg::cfg_t                cfg
);
    import hpid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode one write beat; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:    cfg_next.gain_p        = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    cfg_next.gain_i        = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    cfg_next.gain_d        = cfg_data[GAIN_W-1:0];
                CFG_DEADBAND:  cfg_next.deadband      = cfg_data[DB_W-1:0];
                CFG_MIN_SPEED: cfg_next.min_speed     = cfg_data[PCT_W-1:0];
                CFG_MAX_SPEED: cfg_next.max_speed     = cfg_data[PCT_W-1:0];
                CFG_TIMEOUT:   cfg_next.timeout_ticks = cfg_data[TICK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p        <= GAIN_W'(52429);
            cfg_reg.gain_i        <= GAIN_W'(66);
            cfg_reg.gain_d        <= GAIN_W'(3277);
            cfg_reg.deadband      <= DB_W'(32);
            cfg_reg.min_speed     <= PCT_W'(5);
            cfg_reg.max_speed     <= PCT_W'(50);
            cfg_reg.timeout_ticks <= TICK_W'(250);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/hpid_track.sv */
// ----------------------------------------------------------------------------
// hpid_track
// Turn state and error tracking: wrap, integral, derivative, finish decision.
// ----------------------------------------------------------------------------
module hpid_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        func,
    input  logic [hpid_pkg::HEAD_W-1:0] target_heading,
    input  logic [hpid_pkg::HEAD_W-1:0] measured_heading,
    input  hpid_pkg::cfg_t              cfg,
    output hpid_pkg::track_t            track
);
    import hpid_pkg::*;

    localparam logic signed [DIFF_W-1:0] HALF_S = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] FULL_S = DIFF_W'(FULL_TURN);
    localparam logic signed [ACC_W-1:0]  LIM_P  = ACC_W'(INTEG_LIMIT);
    localparam logic signed [ACC_W-1:0]  LIM_N  = -LIM_P;

    // Turn state
    logic [HEAD_W-1:0]         goal_reg,     goal_next;
    logic signed [INTEG_W-1:0] integ_reg,    integ_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic [TICK_W-1:0]         tick_reg,     tick_next;
    logic                      finished_reg, finished_next;
    status_t                   final_reg,    final_next;
    track_t                    track_reg,    track_next;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  wrapped;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   err_abs;
    logic [AERR_W-1:0]         aerr;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_cl;
    logic signed [DERIV_W-1:0] deriv;
    logic [TICK_W-1:0]         tick_inc;
    logic                      timed;
    logic                      aligned;

    assign track = track_reg;

    // Error wrapped into one half turn either way; one step is enough
    always_comb
    begin
        diff = $signed({1'b0, goal_reg}) - $signed({1'b0, measured_heading});
        priority if (diff > HALF_S)
            wrapped = diff - FULL_S;
        else if (diff <= -HALF_S)
            wrapped = diff + FULL_S;
        else
            wrapped = diff;
        err     = wrapped[ERR_W-1:0];
        err_abs = err[ERR_W-1] ? -err : err;
        aerr    = err_abs[AERR_W-1:0];
    end

    // Integral with reset band and clamp, derivative, tick count
    always_comb
    begin
        acc = ACC_W'(integ_reg) + ACC_W'(err);
        priority if (aerr > AERR_W'(INTEG_RESET_BAND))
            acc_cl = '0;
        else if (acc > LIM_P)
            acc_cl = LIM_P;
        else if (acc < LIM_N)
            acc_cl = LIM_N;
        else
            acc_cl = acc;
        deriv    = DERIV_W'(err) - DERIV_W'(last_err_reg);
        tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + TICK_W'(1);
        timed    = (tick_inc >= cfg.timeout_ticks);
        aligned  = (aerr <= cfg.deadband);
    end

    // Per-item state update and stage result
    always_comb
    begin
        goal_next          = goal_reg;
        integ_next         = integ_reg;
        last_err_next      = last_err_reg;
        tick_next          = tick_reg;
        finished_next      = finished_reg;
        final_next         = final_reg;
        track_next.err     = err;
        track_next.integ   = acc_cl[INTEG_W-1:0];
        track_next.deriv   = deriv;
        track_next.brake   = 1'b1;
        track_next.done    = 1'b0;
        track_next.status  = ST_RUN;
        priority if (func == FUNC_START)
        begin
            goal_next     = target_heading;
            integ_next    = '0;
            last_err_next = '0;
            tick_next     = '0;
            finished_next = 1'b0;
            final_next    = ST_RUN;
        end
        else if (finished_reg)
        begin
            // idle turn: report the latched outcome
            track_next.done   = 1'b1;
            track_next.status = final_reg;
        end
        else
        begin
            integ_next    = acc_cl[INTEG_W-1:0];
            last_err_next = err;
            tick_next     = tick_inc;
            if (timed || aligned)
            begin
                finished_next     = 1'b1;
                final_next        = timed ? ST_TIMEOUT : ST_DONE;
                track_next.done   = 1'b1;
                track_next.status = timed ? ST_TIMEOUT : ST_DONE;
            end
            else
            begin
                // inside the deadband the drive stays zero
                track_next.brake = (aerr < cfg.deadband);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg     <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            tick_reg     <= '0;
            finished_reg <= 1'b1;
            final_reg    <= ST_RUN;
        end
        else if (load)
        begin
            goal_reg     <= goal_next;
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
            tick_reg     <= tick_next;
            finished_reg <= finished_next;
            final_reg    <= final_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            track_reg <= track_next;
        end
    end

endmodule

/* rtl/core/hpid_mult.sv */
// ----------------------------------------------------------------------------
// hpid_mult
// Gain multiply stage: the three P, I and D products, registered.
// ----------------------------------------------------------------------------
module hpid_mult (
    input  logic             clk,
    input  logic             load,
    input  hpid_pkg::track_t track,
    input  hpid_pkg::cfg_t   cfg,
    output hpid_pkg::prod_t  prod
);
    import hpid_pkg::*;

    logic signed [GAIN_W:0] gp_s;
    logic signed [GAIN_W:0] gi_s;
    logic signed [GAIN_W:0] gd_s;
    prod_t                  prod_reg;
    prod_t                  prod_next;

    assign prod = prod_reg;

    // Unsigned gains as non-negative signed operands
    assign gp_s = $signed({1'b0, cfg.gain_p});
    assign gi_s = $signed({1'b0, cfg.gain_i});
    assign gd_s = $signed({1'b0, cfg.gain_d});

    always_comb
    begin
        prod_next.p      = track.err * gp_s;
        prod_next.i      = track.integ * gi_s;
        prod_next.d      = track.deriv * gd_s;
        prod_next.brake  = track.brake;
        prod_next.done   = track.done;
        prod_next.status = track.status;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* rtl/core/hpid_drive.sv */
// ----------------------------------------------------------------------------
// hpid_drive
// Output stage: P+I+D sum, minimum speed, rounding, maximum clamp, result reg.
// ----------------------------------------------------------------------------
module hpid_drive #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         load,
    input  hpid_pkg::prod_t              prod,
    input  hpid_pkg::cfg_t               cfg,
    output logic signed [hpid_pkg::SPEED_W-1:0] left_speed,
    output logic signed [hpid_pkg::SPEED_W-1:0] right_speed,
    output logic                         done_res,
    output logic [1:0]                   status
);
    import hpid_pkg::*;

    localparam int SH    = GAIN_FRAC_BITS + DEG_SHIFT;
    localparam int RND_W = MAG_W + 1;
    localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (SH - 1);

    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   sum_neg;
    logic                      non_pos;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          min_lim;
    logic [RND_W-1:0]          rnd;
    logic [RND_W-1:0]          pct;
    logic [PCT_W-1:0]          pct_cl;
    logic signed [SPEED_W-1:0] spd_pos;
    logic signed [SPEED_W-1:0] speed;

    logic signed [SPEED_W-1:0] speed_reg;
    logic                      done_reg;
    status_t                   status_reg;

    // Sum and magnitude
    always_comb
    begin
        sum     = prod.p + prod.i + prod.d;
        sum_neg = -sum;
        non_pos = sum[SUM_W-1] | (sum == '0);
        mag     = sum[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum[MAG_W-1:0];
    end

    // Minimum speed floor, round half away, maximum clamp
    always_comb
    begin
        min_lim = MAG_W'(cfg.min_speed) << SH;
        rnd     = ({1'b0, mag} + HALF_LSB) >> SH;
        pct     = (mag < min_lim) ? RND_W'(cfg.min_speed) : rnd;
        pct_cl  = (pct > RND_W'(cfg.max_speed)) ? cfg.max_speed : pct[PCT_W-1:0];
        spd_pos = $signed({1'b0, pct_cl});
        priority if (prod.brake)
            speed = '0;
        else if (non_pos)
            speed = -spd_pos;
        else
            speed = spd_pos;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            speed_reg  <= speed;
            done_reg   <= prod.done;
            status_reg <= prod.status;
        end
    end

    assign left_speed  = speed_reg;
    assign right_speed = -speed_reg;
    assign done_res    = done_reg;
    assign status      = status_reg;

endmodule

/* rtl/core/heading_turn_pid_unit.sv */
// ----------------------------------------------------------------------------
// heading_turn_pid_unit
// In-place turn PID on a 1/16 degree heading with opposite wheel drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): func 0 starts a turn toward
//   target_heading; func 1 is one gyro sample in measured_heading.
//   Output channel (out_valid/out_ready): one beat per input beat, in order,
//   with left_speed, right_speed (its negation), done_res and status.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects a register,
//   cfg_data carries its value; always ready, write only while idle.
//   An input beat passes through four registers in order: input register,
//   tracking stage, gain multiply stage, drive and result register.
//   Throughput is one item per cycle while out_ready stays high; the turn
//   state loop closes inside the tracking stage.
//   When the receiver stalls, the stages fill one by one and in_ready drops
//   only once all four hold a beat.
//   Reset empties the pipeline, loads the default gains and limits, and
//   leaves the turn finished: samples then give zero drive, done_res 1.
// ----------------------------------------------------------------------------
module heading_turn_pid_unit #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [hpid_pkg::HEAD_W-1:0]    target_heading,
    input  logic [hpid_pkg::HEAD_W-1:0]    measured_heading,
    // output channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [hpid_pkg::SPEED_W-1:0] left_speed,
    output logic signed [hpid_pkg::SPEED_W-1:0] right_speed,
    output logic                           done_res,
    output logic [1:0]                     status,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpid_pkg::CFG_W-1:0]     cfg_data
);
    import hpid_pkg::*;

    cfg_t   cfg;
    track_t track;
    prod_t  prod;

    // Stage valid bits: input reg, tracking, multiply, result
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic free1, free2, free3;
    logic adv0, adv1, adv2;
    logic in_beat;

    // Input register payload
    logic              func_reg;
    logic [HEAD_W-1:0] target_reg;
    logic [HEAD_W-1:0] meas_reg;

    // Handshake chain: a stage loads when it is empty or drains this cycle
    always_comb
    begin
        free3    = ~v3_reg | out_ready;
        adv2     = v2_reg & free3;
        free2    = ~v2_reg | free3;
        adv1     = v1_reg & free2;
        free1    = ~v1_reg | free2;
        adv0     = v0_reg & free1;
        in_ready = ~v0_reg | free1;
        in_beat  = in_valid & in_ready;
        v0_next  = in_beat | (v0_reg & ~adv0);
        v1_next  = adv0 | (v1_reg & ~adv1);
        v2_next  = adv1 | (v2_reg & ~adv2);
        v3_next  = adv2 | (v3_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            func_reg   <= func;
            target_reg <= target_heading;
            meas_reg   <= measured_heading;
        end
    end

    assign out_valid = v3_reg;

    hpid_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpid_track u_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (adv0),
        .func             (func_reg),
        .target_heading   (target_reg),
        .measured_heading (meas_reg),
        .cfg              (cfg),
        .track            (track)
    );

    hpid_mult u_mult (
        .clk   (clk),
        .load  (adv1),
        .track (track),
        .cfg   (cfg),
        .prod  (prod)
    );

    hpid_drive #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive (
        .clk         (clk),
        .load        (adv2),
        .prod        (prod),
        .cfg         (cfg),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .done_res    (done_res),
        .status      (status)
    );

    // Wheels always turn opposite ways
    a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_speed == -left_speed))
        else $error("right_speed is not the negation of left_speed");

    // A finished turn is braked
    a_done_brake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (left_speed == '0))
        else $error("drive nonzero on a finished turn");

    // A final outcome is only reported with done
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_RUN)) |-> done_res)
        else $error("final status without done_res");

    // An accepted beat always lands in the input stage
    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v0_reg)
        else $error("accepted beat lost at the input stage");

endmodule

/* verif/heading_turn_pid_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_turn_pid_unit_tb
// Self-checking bench for the turn PID. Start and sample beats go in from a
// queue. A local copy of the turn state and the gains predicts each drive
// beat, and the monitor compares every beat that comes out. The run steps
// through several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module heading_turn_pid_unit_tb;

    import hpid_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int SCALE_SH   = FRAC_BITS + DEG_SHIFT;
    localparam int PIPE_DEPTH = 4;

    typedef struct {
        logic                func_code;
        logic [HEAD_W-1:0]   tgt;
        logic [HEAD_W-1:0]   meas;
    } turn_item_t;

    typedef struct {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic                      done;
        status_t                   st;
    } drive_beat_t;

    // DUT signals
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    func = FUNC_START;
    logic [HEAD_W-1:0]       target_heading = '0;
    logic [HEAD_W-1:0]       measured_heading = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                    done_res;
    logic [1:0]              status;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    // Bench state
    turn_item_t  heading_q[$];
    drive_beat_t drive_q[$];
    turn_item_t  drv_item;
    drive_beat_t exp_beat;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatch_cnt = 0;

    // Local copy of the registers and the turn state, at reset values
    cfg_t        cfg_m = '{gain_p: 52429, gain_i: 66, gain_d: 3277, deadband: 32,
                           min_speed: 5, max_speed: 50, timeout_ticks: 250};
    logic [HEAD_W-1:0] goal_h = '0;
    int          integ_acc = 0;
    int          prev_err = 0;
    int          tick_cnt = 0;
    logic        turn_over = 1'b1;
    status_t     over_status = ST_RUN;

    heading_turn_pid_unit #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .target_heading   (target_heading),
        .measured_heading (measured_heading),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .done_res         (done_res),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One controller step: updates the turn state, returns the drive beat
    function automatic drive_beat_t pid_step(input logic fc, input logic [HEAD_W-1:0] tgt,
                                             input logic [HEAD_W-1:0] meas);
        drive_beat_t r;
        int          err, aerr, deriv, spd;
        longint      sum, mag;
        logic        timed, aligned;
        r.left  = '0;
        r.right = '0;
        r.done  = 1'b0;
        r.st    = ST_RUN;
        if (fc == FUNC_START)
        begin
            goal_h      = tgt;
            integ_acc   = 0;
            prev_err    = 0;
            tick_cnt    = 0;
            turn_over   = 1'b0;
            over_status = ST_RUN;
            return r;
        end
        r.done = 1'b1;
        if (turn_over)
        begin
            r.st = over_status;
            return r;
        end

        // heading error wrapped into (-half turn, +half turn]
        err = int'(goal_h) - int'(meas);
        while (err > HALF_TURN)
            err -= FULL_TURN;
        while (err <= -HALF_TURN)
            err += FULL_TURN;
        aerr = (err < 0) ? -err : err;

        // integral with reset on large error and clamp
        integ_acc += err;
        if (aerr > INTEG_RESET_BAND)
            integ_acc = 0;
        if (integ_acc > INTEG_LIMIT)
            integ_acc = INTEG_LIMIT;
        if (integ_acc < -INTEG_LIMIT)
            integ_acc = -INTEG_LIMIT;

        deriv    = err - prev_err;
        prev_err = err;

        // drive: deadband, min speed floor, rounding, max speed clamp
        sum = longint'(err) * longint'(cfg_m.gain_p)
            + longint'(integ_acc) * longint'(cfg_m.gain_i)
            + longint'(deriv) * longint'(cfg_m.gain_d);
        if (aerr < int'(cfg_m.deadband))
            spd = 0;
        else
        begin
            mag = (sum < 0) ? -sum : sum;
            if (mag < (longint'(cfg_m.min_speed) <<< SCALE_SH))
                spd = int'(cfg_m.min_speed);
            else
                spd = int'((mag + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH);
            if (spd > int'(cfg_m.max_speed))
                spd = int'(cfg_m.max_speed);
            if (sum <= 0)
                spd = -spd;
        end

        // finish test on the wrapped error; timeout wins over completion
        if (tick_cnt < 16'hFFFF)
            tick_cnt++;
        timed   = (tick_cnt >= int'(cfg_m.timeout_ticks));
        aligned = (aerr <= int'(cfg_m.deadband));
        if (timed || aligned)
        begin
            turn_over   = 1'b1;
            over_status = timed ? ST_TIMEOUT : ST_DONE;
            r.st        = over_status;
            return r;
        end
        r.done  = 1'b0;
        r.left  = 8'(spd);
        r.right = 8'(-spd);
        return r;
    endfunction

    // Input driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid         <= 1'b0;
            func             <= FUNC_START;
            target_heading   <= '0;
            measured_heading <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                drive_q.push_back(pid_step(func, target_heading, measured_heading));
            if (!in_valid || in_ready)
            begin
                if (heading_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item         = heading_q.pop_front();
                    in_valid         <= 1'b1;
                    func             <= drv_item.func_code;
                    target_heading   <= drv_item.tgt;
                    measured_heading <= drv_item.meas;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_q.size() == 0)
                begin
                    $display("%0t: unexpected drive beat: left %0d right %0d done %0b status %0d",
                             $time, left_speed, right_speed, done_res, status);
                    mismatch_cnt++;
                end
                else
                begin
                    exp_beat = drive_q.pop_front();
                    if (left_speed !== exp_beat.left || right_speed !== exp_beat.right ||
                        done_res !== exp_beat.done || status !== exp_beat.st)
                    begin
                        $display("%0t: drive beat expected left %0d right %0d done %0b status %0d, actual left %0d right %0d done %0b status %0d",
                                 $time, exp_beat.left, exp_beat.right, exp_beat.done,
                                 exp_beat.st, left_speed, right_speed, done_res, status);
                        mismatch_cnt++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic fc, input logic [HEAD_W-1:0] tgt,
                             input logic [HEAD_W-1:0] meas);
        turn_item_t it;
        it.func_code = fc;
        it.tgt       = tgt;
        it.meas      = meas;
        heading_q.push_back(it);
    endtask

    // Register write; only called with the pipeline empty
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_P:    cfg_m.gain_p        = val;
            CFG_GAIN_I:    cfg_m.gain_i        = val;
            CFG_GAIN_D:    cfg_m.gain_d        = val;
            CFG_DEADBAND:  cfg_m.deadband      = val[DB_W-1:0];
            CFG_MIN_SPEED: cfg_m.min_speed     = val[PCT_W-1:0];
            CFG_MAX_SPEED: cfg_m.max_speed     = val[PCT_W-1:0];
            CFG_TIMEOUT:   cfg_m.timeout_ticks = val[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Sender holds off until every predicted beat has come back
    task automatic wait_drained();
        while (heading_q.size() != 0 || in_valid || drive_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Heading a given offset from the goal, sometimes past a full turn
    function automatic logic [HEAD_W-1:0] to_heading(input int h);
        int m;
        m = h % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        if (m < 8192 - FULL_TURN && $urandom_range(9) == 0)
            m += FULL_TURN;
        return HEAD_W'(m);
    endfunction

    // Random turns: start then a run of samples that converge, hold an
    // offset, jump around or overshoot; a little raw noise in between
    task automatic gen_turns(input int n);
        int                cnt, len, style, off;
        logic [HEAD_W-1:0] tgt;
        cnt = 0;
        while (cnt < n)
        begin
            if ($urandom_range(99) < 8)
            begin
                push_item(1'($urandom_range(1)), HEAD_W'($urandom), HEAD_W'($urandom));
                cnt++;
            end
            else
            begin
                tgt = ($urandom_range(9) == 0) ? HEAD_W'($urandom)
                                               : HEAD_W'($urandom_range(FULL_TURN - 1));
                push_item(FUNC_START, tgt, HEAD_W'($urandom));
                len   = $urandom_range(1, 40);
                style = $urandom_range(3);
                if (style == 1)
                    off = int'($urandom_range(1600)) - 800;
                else
                    off = int'($urandom_range(FULL_TURN)) - HALF_TURN;
                cnt += 1 + len;
                repeat (len)
                begin
                    push_item(FUNC_SAMPLE, HEAD_W'($urandom), to_heading(int'(tgt) - off));
                    case (style)
                        0: off = off * int'($urandom_range(3, 7)) / 8
                                 + int'($urandom_range(6)) - 3;
                        1: off = off + int'($urandom_range(4)) - 2;
                        2: off = int'($urandom_range(FULL_TURN)) - HALF_TURN;
                        default: off = -off * int'($urandom_range(2, 6)) / 8
                                       + int'($urandom_range(6)) - 3;
                    endcase
                end
            end
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 30;
        recv_stall_pct = 51;

        // directed: reset defaults
        push_item(FUNC_SAMPLE, 13'd0, 13'd123);     // sample before any start
        push_item(FUNC_START, 13'd0, 13'd0);
        push_item(FUNC_SAMPLE, 13'h1555, 13'd1440);
        push_item(FUNC_SAMPLE, 13'd0, 13'd8191);    // heading beyond range
        push_item(FUNC_SAMPLE, 13'h1FFF, 13'd2880); // raw error exactly minus half turn
        push_item(FUNC_SAMPLE, 13'd0, 13'd4000);
        push_item(FUNC_SAMPLE, 13'd0, 13'd5700);
        push_item(FUNC_SAMPLE, 13'd0, 13'd5759);    // inside band: completes
        push_item(FUNC_SAMPLE, 13'd0, 13'd3000);    // after finish
        push_item(FUNC_START, 13'd8191, 13'd8191);
        push_item(FUNC_SAMPLE, 13'd0, 13'd0);
        push_item(FUNC_SAMPLE, 13'd0, 13'd5759);
        push_item(FUNC_SAMPLE, 13'd0, 13'd8150);
        push_item(FUNC_SAMPLE, 13'd0, 13'd8159);    // error equal to deadband
        push_item(FUNC_START, 13'd100, 13'd0);
        push_item(FUNC_START, 13'd2880, 13'd0);     // start over a running turn
        push_item(FUNC_SAMPLE, 13'd0, 13'd0);
        push_item(FUNC_SAMPLE, 13'd0, 13'd5760);
        push_item(FUNC_SAMPLE, 13'd0, 13'd2870);
        wait_drained();

        gen_turns(200);
        wait_drained();

        // all-ones gains, no deadband, widest speeds, longest timeout
        write_reg(CFG_GAIN_P, 20'hFFFFF);
        write_reg(CFG_GAIN_I, 20'hFFFFF);
        write_reg(CFG_GAIN_D, 20'hFFFFF);
        write_reg(CFG_DEADBAND, 20'd0);
        write_reg(CFG_MIN_SPEED, 20'd127);
        write_reg(CFG_MAX_SPEED, 20'd127);
        write_reg(CFG_TIMEOUT, 20'd65535);
        gen_turns(200);
        wait_drained();

        send_idle_pct  = 51;
        recv_stall_pct = 30;

        // zero timeout: first sample of every turn times out
        write_reg(CFG_DEADBAND, 20'd1);
        write_reg(CFG_MIN_SPEED, 20'd7);
        write_reg(CFG_MAX_SPEED, 20'd100);
        write_reg(CFG_TIMEOUT, 20'd0);
        gen_turns(80);
        wait_drained();

        // zero gains and min speed above max speed
        write_reg(CFG_GAIN_P, 20'd0);
        write_reg(CFG_GAIN_I, 20'd0);
        write_reg(CFG_GAIN_D, 20'd0);
        write_reg(CFG_DEADBAND, 20'd0);
        write_reg(CFG_MIN_SPEED, 20'd20);
        write_reg(CFG_MAX_SPEED, 20'd10);
        write_reg(CFG_TIMEOUT, 20'd65535);
        gen_turns(200);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // widest deadband with one-sample timeout: both finish tests at once
        write_reg(CFG_GAIN_P, 20'($urandom_range(200000)));
        write_reg(CFG_GAIN_I, 20'($urandom_range(2000)));
        write_reg(CFG_GAIN_D, 20'($urandom_range(50000)));
        write_reg(CFG_DEADBAND, 20'hFFF);
        write_reg(CFG_MIN_SPEED, 20'd0);
        write_reg(CFG_MAX_SPEED, 20'd0);
        write_reg(CFG_TIMEOUT, 20'd1);
        gen_turns(80);
        wait_drained();

        // random moderate settings, two bursts
        write_reg(CFG_GAIN_P, 20'($urandom_range(200000)));
        write_reg(CFG_GAIN_I, 20'($urandom_range(2000)));
        write_reg(CFG_GAIN_D, 20'($urandom_range(50000)));
        write_reg(CFG_DEADBAND, 20'($urandom_range(64)));
        write_reg(CFG_MIN_SPEED, 20'($urandom_range(20)));
        write_reg(CFG_MAX_SPEED, 20'($urandom_range(100)));
        write_reg(CFG_TIMEOUT, 20'($urandom_range(5, 60)));
        gen_turns(150);
        wait_drained();
        gen_turns(150);
        wait_drained();

        // default gains, narrow band, no floor: integral reaches its clamp
        write_reg(CFG_GAIN_P, 20'd52429);
        write_reg(CFG_GAIN_I, 20'd66);
        write_reg(CFG_GAIN_D, 20'd3277);
        write_reg(CFG_DEADBAND, 20'd8);
        write_reg(CFG_MIN_SPEED, 20'd0);
        write_reg(CFG_MAX_SPEED, 20'd100);
        write_reg(CFG_TIMEOUT, 20'd65535);
        gen_turns(250);
        wait_drained();

        if (drive_q.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hpid_pkg.sv
rtl/core/hpid_cfg_regs.sv
rtl/core/hpid_track.sv
rtl/core/hpid_mult.sv
rtl/core/hpid_drive.sv
rtl/core/heading_turn_pid_unit.sv
verif/heading_turn_pid_unit_tb.sv
